// ===== rtl/core/ellc_pkg.sv =====
// Package with the constants, types and arctangent table of the ellipsoid conversion.
`timescale 1ns / 1ps
package ellc_pkg;

  localparam int unsigned CordicStagesDef  = 20;
  localparam int unsigned AngleFracBitsDef = 16;
  localparam int unsigned LatWidth   = 24;
  localparam int unsigned LonWidth   = 26;
  localparam int unsigned RadWidth   = 24;
  localparam int unsigned OutWidth   = 25;
  localparam int unsigned CfgIdxWidth = 1;

  // Configuration register indexes.
  localparam logic [CfgIdxWidth-1:0] RegEquatorial = 1'b0;
  localparam logic [CfgIdxWidth-1:0] RegPolar      = 1'b1;

  localparam logic [RadWidth-1:0] EquatorialReset = 24'd6378100;
  localparam logic [RadWidth-1:0] PolarReset      = 24'd6356800;

  // CORDIC datapath width: Q30 values, guard bits for growth.
  localparam int unsigned CW = 34;
  localparam logic signed [CW-1:0] CordicStart = 34'sh026DD3B6A;
  localparam logic signed [CW-1:0] OneQ30      = 34'sh040000000;
  localparam longint RadiusMax = 64'd16777215;

  // Degree to radian factor: ((pi * 2^40) + 90) / 180.
  localparam int unsigned DegToRadWidth = 35;
  localparam logic [DegToRadWidth-1:0] DegToRad = 35'd19190098069;

  // Arctangent of 2^-i in Q30, rounded.
  function automatic logic signed [CW-1:0] atan_q30(input logic [4:0] idx);
    logic signed [CW-1:0] r;
    case (idx)
      5'd0:  r = 34'sd843314857;
      5'd1:  r = 34'sd497837829;
      5'd2:  r = 34'sd263043837;
      5'd3:  r = 34'sd133525159;
      5'd4:  r = 34'sd67021687;
      5'd5:  r = 34'sd33543516;
      5'd6:  r = 34'sd16775851;
      5'd7:  r = 34'sd8388437;
      5'd8:  r = 34'sd4194283;
      5'd9:  r = 34'sd2097149;
      5'd10: r = 34'sd1048576;
      5'd11: r = 34'sd524288;
      5'd12: r = 34'sd262144;
      5'd13: r = 34'sd131072;
      5'd14: r = 34'sd65536;
      5'd15: r = 34'sd32768;
      5'd16: r = 34'sd16384;
      5'd17: r = 34'sd8192;
      5'd18: r = 34'sd4096;
      5'd19: r = 34'sd2048;
      5'd20: r = 34'sd1024;
      5'd21: r = 34'sd512;
      5'd22: r = 34'sd256;
      5'd23: r = 34'sd128;
      5'd24: r = 34'sd64;
      5'd25: r = 34'sd32;
      5'd26: r = 34'sd16;
      5'd27: r = 34'sd8;
      5'd28: r = 34'sd4;
      5'd29: r = 34'sd2;
      5'd30: r = 34'sd1;
      5'd31: r = 34'sd1;
      default: r = 34'sd0;
    endcase
    return r;
  endfunction

  // One angle on its way through the CORDIC.
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 cos_neg;
  } cordic_t;

endpackage

// ===== rtl/core/ellc_prep.sv =====
// Angle reduction, folding and conversion to Q30 radians, three register stages.
`timescale 1ns / 1ps
module ellc_prep #(
  parameter int unsigned AngleFracBits = ellc_pkg::AngleFracBitsDef,
  parameter int unsigned InWidth = 26
) (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic signed [InWidth-1:0]  angle_i,
  output ellc_pkg::cordic_t          angle_o
);
  import ellc_pkg::*;

  // Wide enough for the input and for one full turn at any fraction width.
  localparam int unsigned AW =
    ((InWidth > AngleFracBits + 9) ? InWidth : AngleFracBits + 9) + 2;
  localparam logic signed [AW-1:0] Turn    = AW'(360) <<< AngleFracBits;
  localparam logic signed [AW-1:0] Half    = AW'(180) <<< AngleFracBits;
  localparam logic signed [AW-1:0] Quarter = AW'(90) <<< AngleFracBits;
  localparam int unsigned Sh = 10 + AngleFracBits;
  localparam int unsigned PW = AW + DegToRadWidth;

  logic signed [AW-1:0] a_ext, r_w, f_w;
  logic signed [AW-1:0] r_q;
  logic                 neg_w, cneg_w;
  logic        [AW-1:0] mag_d, mag_q;
  logic                 neg_q, cneg_q, cneg2_q, cos_neg_q;
  logic        [PW-1:0] prod_d;
  logic        [PW-1:0] prod_q;
  logic signed [CW-1:0] z_w;

  // Reduce to [-180, 180) by a bounded number of turn steps.
  always_comb begin
    a_ext = AW'(angle_i);
    r_w = a_ext;
    for (int k = 0; k < 2; k++) begin
      if (r_w >= Half) r_w = r_w - Turn;
      else if (r_w < -Half) r_w = r_w + Turn;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) r_q <= r_w;
  end

  // Fold into the right half plane and take the magnitude.
  always_comb begin
    f_w = r_q;
    cneg_w = 1'b0;
    if (r_q > Quarter) begin
      f_w = Half - r_q;
      cneg_w = 1'b1;
    end else if (r_q < -Quarter) begin
      f_w = -Half - r_q;
      cneg_w = 1'b1;
    end
    neg_w = f_w < 0;
    mag_d = neg_w ? AW'(-f_w) : AW'(f_w);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q  <= mag_d;
      neg_q  <= neg_w;
      cneg_q <= cneg_w;
    end
  end

  assign prod_d = PW'(mag_q) * PW'(DegToRad) + (PW'(1) << (Sh - 1));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q    <= prod_d;
      cos_neg_q <= cneg_q;
      cneg2_q   <= neg_q;
    end
  end

  assign z_w = CW'(prod_q >> Sh);

  always_comb begin
    angle_o.x = CordicStart;
    angle_o.y = '0;
    angle_o.z = cneg2_q ? -z_w : z_w;
    angle_o.cos_neg = cos_neg_q;
  end

endmodule

// ===== rtl/core/ellc_cordic.sv =====
// Unrolled rotation-mode CORDIC, one register stage per iteration, with saturation.
`timescale 1ns / 1ps
module ellc_cordic #(
  parameter int unsigned CordicStages = ellc_pkg::CordicStagesDef
) (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  ellc_pkg::cordic_t         angle_i,
  output logic signed [ellc_pkg::CW-1:0] cos_o,
  output logic signed [ellc_pkg::CW-1:0] sin_o
);
  import ellc_pkg::*;

  cordic_t stage_q [CordicStages+1];
  logic signed [CW-1:0] cx, cy;

  assign stage_q[0] = angle_i;

  // One micro-rotation per stage.
  for (genvar i = 0; i < CordicStages; i++) begin : g_stage
    cordic_t nxt;
    always_comb begin
      nxt = stage_q[i];
      if (i < 32) begin
        if (stage_q[i].z >= 0) begin
          nxt.x = stage_q[i].x - (stage_q[i].y >>> i);
          nxt.y = stage_q[i].y + (stage_q[i].x >>> i);
          nxt.z = stage_q[i].z - atan_q30(5'(i));
        end else begin
          nxt.x = stage_q[i].x + (stage_q[i].y >>> i);
          nxt.y = stage_q[i].y - (stage_q[i].x >>> i);
          nxt.z = stage_q[i].z + atan_q30(5'(i));
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) stage_q[i+1] <= nxt;
    end
  end

  // Saturate to one and apply the cosine sign of the fold.
  always_comb begin
    cx = stage_q[CordicStages].x;
    cy = stage_q[CordicStages].y;
    if (cx > OneQ30) cx = OneQ30;
    else if (cx < -OneQ30) cx = -OneQ30;
    if (cy > OneQ30) cy = OneQ30;
    else if (cy < -OneQ30) cy = -OneQ30;
    cos_o = stage_q[CordicStages].cos_neg ? -cx : cx;
    sin_o = cy;
  end

endmodule

// ===== rtl/core/ellc_scale.sv =====
// Radius products, rounding and saturation to whole metres, three register stages.
`timescale 1ns / 1ps
module ellc_scale (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic [ellc_pkg::RadWidth-1:0]  eq_rad_i,
  input  logic [ellc_pkg::RadWidth-1:0]  pol_rad_i,
  input  logic signed [ellc_pkg::CW-1:0] clat_i,
  input  logic signed [ellc_pkg::CW-1:0] slat_i,
  input  logic signed [ellc_pkg::CW-1:0] clon_i,
  input  logic signed [ellc_pkg::CW-1:0] slon_i,
  output logic signed [ellc_pkg::OutWidth-1:0] x_o,
  output logic signed [ellc_pkg::OutWidth-1:0] y_o,
  output logic signed [ellc_pkg::OutWidth-1:0] z_o
);
  import ellc_pkg::*;

  logic signed [63:0] ac_q, bz_q, d_w, xp_q, yp_q, zr_q;
  logic signed [CW-1:0] clon_q, slon_q;
  logic signed [63:0] xr, yr;

  function automatic logic signed [OutWidth-1:0] sat(input logic signed [63:0] v);
    if (v > RadiusMax) return OutWidth'(RadiusMax);
    if (v < -RadiusMax) return OutWidth'(-RadiusMax);
    return OutWidth'(v);
  endfunction

  // First products: a*cos(lat) and b*sin(lat).
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ac_q   <= $signed({40'd0, eq_rad_i}) * 64'(clat_i);
      bz_q   <= $signed({40'd0, pol_rad_i}) * 64'(slat_i);
      clon_q <= clon_i;
      slon_q <= slon_i;
    end
  end

  assign d_w = (ac_q + 64'sd2097152) >>> 22;

  // Longitude products, with the z term rounded alongside.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xp_q <= d_w * 64'(clon_q);
      yp_q <= d_w * 64'(slon_q);
      zr_q <= (bz_q + 64'sd536870912) >>> 30;
    end
  end

  assign xr = (xp_q + 64'sd137438953472) >>> 38;
  assign yr = (yp_q + 64'sd137438953472) >>> 38;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_o <= sat(xr);
      y_o <= sat(yr);
      z_o <= sat(zr_q);
    end
  end

endmodule

// ===== rtl/core/ellipsoid_latlon_to_cartesian.sv =====
// Top level of the latitude and longitude to ellipsoid cartesian converter.
// Usage:
//   Requests enter on in_valid/in_stall with latitude_i and longitude_i in
//   degrees, signed, ANGLE_FRAC_BITS fraction bits. Each request yields one
//   result on out_valid/out_stall: x, y, z in metres and map_u = y, map_v = z.
//   The radii are set over the cfg_valid/cfg_ready port, index 0 equatorial,
//   index 1 polar; other indexes are ignored. Write them only while idle.
// Pipeline and throughput:
//   A request passes through the angle reduction and radian conversion
//   registers, the CORDIC stages and the radius product registers, in order.
//   One request is taken every cycle while the pipeline is not stalled.
// Reset:
//   The pipeline empties and the radii return to 6378100 m and 6356800 m.
// Stall:
//   When the receiver stalls with a result waiting, the whole pipeline holds
//   and in_stall_o rises; nothing is lost or repeated.
`timescale 1ns / 1ps
module ellipsoid_latlon_to_cartesian #(
  parameter int unsigned CORDIC_STAGES   = ellc_pkg::CordicStagesDef,
  parameter int unsigned ANGLE_FRAC_BITS = ellc_pkg::AngleFracBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  logic signed [ellc_pkg::LatWidth-1:0] latitude_i,
  input  logic signed [ellc_pkg::LonWidth-1:0] longitude_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output logic signed [ellc_pkg::OutWidth-1:0] x_coord_o,
  output logic signed [ellc_pkg::OutWidth-1:0] y_coord_o,
  output logic signed [ellc_pkg::OutWidth-1:0] z_coord_o,
  output logic signed [ellc_pkg::OutWidth-1:0] map_u_o,
  output logic signed [ellc_pkg::OutWidth-1:0] map_v_o,
  input  logic cfg_valid_i,
  output logic cfg_ready_o,
  input  logic [ellc_pkg::CfgIdxWidth-1:0] cfg_index_i,
  input  logic [ellc_pkg::RadWidth-1:0] cfg_data_i
);
  import ellc_pkg::*;

  localparam int unsigned Depth = CORDIC_STAGES + 6;

  logic [RadWidth-1:0] eq_rad_q, pol_rad_q;
  logic [Depth-1:0]    valid_q, valid_d;
  logic                en;
  cordic_t             lat_a, lon_a;
  logic signed [CW-1:0] clat, slat, clon, slon;

  // The pipeline moves unless a finished result is held by the receiver.
  assign en          = !(valid_q[Depth-1] && out_stall_i);
  assign in_stall_o  = !en;
  assign out_valid_o = valid_q[Depth-1];
  assign cfg_ready_o = 1'b1;

  // Radius registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eq_rad_q  <= EquatorialReset;
      pol_rad_q <= PolarReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegEquatorial: eq_rad_q  <= cfg_data_i;
        RegPolar:      pol_rad_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Valid bits travel with the data.
  assign valid_d = {valid_q[Depth-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= '0;
    else if (en) valid_q <= valid_d;
  end

  ellc_prep #(.AngleFracBits(ANGLE_FRAC_BITS), .InWidth(LonWidth)) u_prep_lat (
    .clk_i(clk_i), .en_i(en), .angle_i(LonWidth'(latitude_i)), .angle_o(lat_a)
  );
  ellc_prep #(.AngleFracBits(ANGLE_FRAC_BITS), .InWidth(LonWidth)) u_prep_lon (
    .clk_i(clk_i), .en_i(en), .angle_i(longitude_i), .angle_o(lon_a)
  );

  ellc_cordic #(.CordicStages(CORDIC_STAGES)) u_cordic_lat (
    .clk_i(clk_i), .en_i(en), .angle_i(lat_a), .cos_o(clat), .sin_o(slat)
  );
  ellc_cordic #(.CordicStages(CORDIC_STAGES)) u_cordic_lon (
    .clk_i(clk_i), .en_i(en), .angle_i(lon_a), .cos_o(clon), .sin_o(slon)
  );

  ellc_scale u_scale (
    .clk_i(clk_i), .en_i(en),
    .eq_rad_i(eq_rad_q), .pol_rad_i(pol_rad_q),
    .clat_i(clat), .slat_i(slat), .clon_i(clon), .slon_i(slon),
    .x_o(x_coord_o), .y_o(y_coord_o), .z_o(z_coord_o)
  );

  assign map_u_o = y_coord_o;
  assign map_v_o = z_coord_o;

endmodule
